[rtl/mpss_pkg.sv]
// ----------------------------------------------------------------------------
// mpss_pkg
// Shared types, codes and sizing functions for the motif PWM strand scorer.
// ----------------------------------------------------------------------------
`default_nettype none

package mpss_pkg;

  localparam int MPSS_MOTIF_LEN   = 10;
  localparam int MPSS_WEIGHT_BITS = 16;
  localparam int FIELD_WEIGHT_W   = 16;
  localparam int QUEUE_DEPTH      = 4;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_SCORE = 1'b1;

  localparam logic [1:0] COMPLEMENT [4] = '{2'd3, 2'd2, 2'd1, 2'd0};

  typedef enum logic {
    JOB_LOAD,
    JOB_SCORE
  } job_kind_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_READ,
    BK_ABS,
    BK_DIV,
    BK_DONE
  } bk_state_t;

  function automatic int stored_bits(input int wb);
    return (wb < FIELD_WEIGHT_W) ? wb : FIELD_WEIGHT_W;
  endfunction

  function automatic int row_bits(input int len);
    return (len > 1) ? $clog2(len) : 1;
  endfunction

  // kind + row/column address + weight + window + window start
  function automatic int job_bits(input int len, input int wb);
    return 1 + row_bits(len) + 2 + stored_bits(wb) + 2 * len + 32;
  endfunction

endpackage

`default_nettype wire

[rtl/mpss_queue.sv]
// ----------------------------------------------------------------------------
// mpss_queue
// Small job queue between the front end and the scoring back end.
// ----------------------------------------------------------------------------
`default_nettype none

module mpss_queue
  import mpss_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             q_push,
  input  wire logic [WIDTH-1:0] q_wdata,
  output      logic             q_full,
  input  wire logic             q_pop,
  output      logic [WIDTH-1:0] q_rdata,
  output      logic             q_empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign q_full  = (cnt_r == CW'(DEPTH));
  assign q_empty = (cnt_r == '0);
  assign q_rdata = slot_r[rd_ptr_r];
  assign do_push = q_push && !q_full;
  assign do_pop  = q_pop && !q_empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= q_wdata;
    end
  end

endmodule

`default_nettype wire

[rtl/mpss_front.sv]
// ----------------------------------------------------------------------------
// mpss_front
// Takes input transactions, keeps the base window and sequence counters,
// and queues weight loads and full-window score jobs.
// ----------------------------------------------------------------------------
`default_nettype none

module mpss_front
  import mpss_pkg::*;
#(
  parameter int MOTIF_LEN   = MPSS_MOTIF_LEN,
  parameter int WEIGHT_BITS = MPSS_WEIGHT_BITS
) (
  input  wire logic                                     clk,
  input  wire logic                                     rst_n,
  input  wire logic                                     in_push,
  output      logic                                     in_full,
  input  wire logic                                     in_opcode,
  input  wire logic                                     in_first_of_sequence,
  input  wire logic [1:0]                               in_base,
  input  wire logic [3:0]                               in_motif_position,
  input  wire logic signed [FIELD_WEIGHT_W-1:0]         in_weight,
  output      logic                                     q_push,
  output      logic [job_bits(MOTIF_LEN, WEIGHT_BITS)-1:0] q_wdata,
  input  wire logic                                     q_full
);

  localparam int WS = stored_bits(WEIGHT_BITS);
  localparam int RW = row_bits(MOTIF_LEN);
  localparam int AW = RW + 2;
  localparam int CW = $clog2(MOTIF_LEN + 1);

  typedef struct packed {
    job_kind_t                   kind;
    logic [AW-1:0]               addr;
    logic [WS-1:0]               weight;
    logic [MOTIF_LEN-1:0][1:0]   win;
    logic [31:0]                 wstart;
  } job_t;

  logic [MOTIF_LEN-1:0][1:0] win_r, win_nxt, win_sh;
  logic [CW-1:0]             seen_r, seen_nxt, seen_base;
  logic [31:0]               pos_r, pos_nxt, pos_base;
  logic                      accept;
  logic                      row_ok;
  job_t                      job;

  assign in_full = q_full;
  assign accept  = in_push && !q_full;
  assign row_ok  = (8'(in_motif_position) < 8'(MOTIF_LEN));
  assign q_wdata = job;

  always_comb begin
    for (int i = 0; i < MOTIF_LEN - 1; i++) begin
      win_sh[i] = win_r[i + 1];
    end
    win_sh[MOTIF_LEN - 1] = in_base;
  end

  always_comb begin
    seen_base = in_first_of_sequence ? '0 : seen_r;
    pos_base  = in_first_of_sequence ? '0 : pos_r;
    win_nxt   = win_r;
    seen_nxt  = seen_r;
    pos_nxt   = pos_r;
    job       = '0;
    q_push    = 1'b0;
    if (accept) begin
      if (in_opcode == OP_LOAD) begin
        job.kind   = JOB_LOAD;
        job.addr   = {RW'(in_motif_position), in_base};
        job.weight = in_weight[WS-1:0];
        q_push     = row_ok;
      end else begin
        win_nxt    = win_sh;
        pos_nxt    = pos_base + 32'd1;
        seen_nxt   = (seen_base < CW'(MOTIF_LEN)) ? seen_base + CW'(1) : seen_base;
        job.kind   = JOB_SCORE;
        job.win    = win_sh;
        job.wstart = pos_nxt - 32'(MOTIF_LEN);
        q_push     = (seen_nxt == CW'(MOTIF_LEN));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r  <= '0;
      seen_r <= '0;
      pos_r  <= '0;
    end else begin
      win_r  <= win_nxt;
      seen_r <= seen_nxt;
      pos_r  <= pos_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/mpss_back.sv]
// ----------------------------------------------------------------------------
// mpss_back
// Runs queued jobs: writes the weight table, walks the window reading both
// strands' weights, divides the sums by the motif length, holds the result.
// ----------------------------------------------------------------------------
`default_nettype none

module mpss_back
  import mpss_pkg::*;
#(
  parameter int MOTIF_LEN   = MPSS_MOTIF_LEN,
  parameter int WEIGHT_BITS = MPSS_WEIGHT_BITS
) (
  input  wire logic                                        clk,
  input  wire logic                                        rst_n,
  input  wire logic                                        q_empty,
  input  wire logic [job_bits(MOTIF_LEN, WEIGHT_BITS)-1:0] q_rdata,
  output      logic                                        q_pop,
  output      logic                                        out_empty,
  input  wire logic                                        out_pop,
  output      logic signed [15:0]                          out_forward_mean,
  output      logic signed [15:0]                          out_revcomp_mean,
  output      logic [31:0]                                 out_window_start
);

  localparam int WS    = stored_bits(WEIGHT_BITS);
  localparam int RW    = row_bits(MOTIF_LEN);
  localparam int AW    = RW + 2;
  localparam int DEPTH = MOTIF_LEN * 4;
  localparam int KW    = $clog2(MOTIF_LEN + 1);
  localparam int SUM_W = WS + $clog2(MOTIF_LEN) + 1;
  localparam int SHIFT = SUM_W + $clog2(MOTIF_LEN);
  localparam int MW    = SUM_W + 1;
  localparam int PW    = SUM_W + MW;
  localparam longint RECIP =
    ((longint'(1) << SHIFT) + longint'(MOTIF_LEN) - 1) / longint'(MOTIF_LEN);
  localparam logic [MW-1:0] RECIP_C = MW'(RECIP);

  typedef struct packed {
    job_kind_t                   kind;
    logic [AW-1:0]               addr;
    logic [WS-1:0]               weight;
    logic [MOTIF_LEN-1:0][1:0]   win;
    logic [31:0]                 wstart;
  } job_t;

  job_t                      job;
  bk_state_t                 state_r, state_nxt;

  logic signed [WS-1:0]      wtab [DEPTH];
  logic signed [WS-1:0]      rd_f_r, rd_r_r;
  logic [AW-1:0]             addr_f, addr_r;

  logic [MOTIF_LEN-1:0][1:0] win_r, win_sh;
  logic [31:0]               wstart_r;
  logic [RW-1:0]             f_row_r, r_row_r;
  logic [KW-1:0]             k_r;
  logic signed [SUM_W-1:0]   sum_f_r, sum_r_r;
  logic                      neg_f_r, neg_r_r;
  logic [SUM_W-1:0]          mag_f_r, mag_r_r;
  logic [PW-1:0]             prod_f, prod_r;
  logic signed [SUM_W-1:0]   q_f_s, q_r_s;

  logic                      out_valid_r;
  logic signed [15:0]        out_fwd_r, out_rev_r;
  logic [31:0]               out_ws_r;

  logic wr_en, start_score, issue, acc, out_load;

  assign job = q_rdata;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (!q_empty && job.kind == JOB_SCORE) begin
          state_nxt = BK_READ;
        end
      end
      BK_READ: begin
        if (k_r == KW'(MOTIF_LEN)) begin
          state_nxt = BK_ABS;
        end
      end
      BK_ABS: begin
        state_nxt = BK_DIV;
      end
      BK_DIV: begin
        state_nxt = BK_DONE;
      end
      BK_DONE: begin
        if (out_load) begin
          state_nxt = BK_IDLE;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  // control outputs
  always_comb begin
    q_pop       = 1'b0;
    wr_en       = 1'b0;
    start_score = 1'b0;
    issue       = 1'b0;
    acc         = 1'b0;
    out_load    = 1'b0;
    case (state_r)
      BK_IDLE: begin
        q_pop       = !q_empty;
        wr_en       = !q_empty && job.kind == JOB_LOAD;
        start_score = !q_empty && job.kind == JOB_SCORE;
      end
      BK_READ: begin
        issue = (k_r < KW'(MOTIF_LEN));
        acc   = (k_r != '0);
      end
      BK_DONE: begin
        out_load = !out_valid_r || out_pop;
      end
      default: begin
        q_pop = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // weight table, one write and two registered reads
  assign addr_f = {f_row_r, win_r[0]};
  assign addr_r = {r_row_r, COMPLEMENT[win_r[0]]};

  always_ff @(posedge clk) begin
    if (wr_en) begin
      wtab[job.addr] <= job.weight;
    end
    rd_f_r <= wtab[addr_f];
    rd_r_r <= wtab[addr_r];
  end

  always_comb begin
    for (int i = 0; i < MOTIF_LEN - 1; i++) begin
      win_sh[i] = win_r[i + 1];
    end
    win_sh[MOTIF_LEN - 1] = 2'd0;
  end

  // division by the motif length as a multiply by a rounded-up reciprocal,
  // exact for every magnitude below 2**SUM_W
  assign prod_f = PW'(mag_f_r) * PW'(RECIP_C);
  assign prod_r = PW'(mag_r_r) * PW'(RECIP_C);

  assign q_f_s = neg_f_r ? -$signed(mag_f_r) : $signed(mag_f_r);
  assign q_r_s = neg_r_r ? -$signed(mag_r_r) : $signed(mag_r_r);

  always_ff @(posedge clk) begin
    if (start_score) begin
      win_r    <= job.win;
      wstart_r <= job.wstart;
      f_row_r  <= '0;
      r_row_r  <= RW'(MOTIF_LEN - 1);
      k_r      <= '0;
      sum_f_r  <= '0;
      sum_r_r  <= '0;
    end
    if (state_r == BK_READ) begin
      k_r <= k_r + KW'(1);
    end
    if (issue) begin
      win_r   <= win_sh;
      f_row_r <= f_row_r + RW'(1);
      r_row_r <= r_row_r - RW'(1);
    end
    if (acc) begin
      sum_f_r <= sum_f_r + SUM_W'(rd_f_r);
      sum_r_r <= sum_r_r + SUM_W'(rd_r_r);
    end
    if (state_r == BK_ABS) begin
      neg_f_r <= sum_f_r[SUM_W-1];
      neg_r_r <= sum_r_r[SUM_W-1];
      mag_f_r <= sum_f_r[SUM_W-1] ? SUM_W'(-sum_f_r) : SUM_W'(sum_f_r);
      mag_r_r <= sum_r_r[SUM_W-1] ? SUM_W'(-sum_r_r) : SUM_W'(sum_r_r);
    end
    if (state_r == BK_DIV) begin
      mag_f_r <= SUM_W'(prod_f >> SHIFT);
      mag_r_r <= SUM_W'(prod_r >> SHIFT);
    end
    if (out_load) begin
      out_fwd_r <= 16'(q_f_s);
      out_rev_r <= 16'(q_r_s);
      out_ws_r  <= wstart_r;
    end
  end

  assign out_empty        = !out_valid_r;
  assign out_forward_mean = out_fwd_r;
  assign out_revcomp_mean = out_rev_r;
  assign out_window_start = out_ws_r;

`ifndef NO_ASSERTIONS
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("job popped from empty queue");

  a_wr_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (int'(job.addr) < DEPTH))
    else $error("weight write outside table");

  a_read_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_READ) |-> (k_r <= KW'(MOTIF_LEN)))
    else $error("read walk overran motif length");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == BK_DONE))
    else $error("result posted outside done state");
`endif

endmodule

`default_nettype wire

[rtl/motif_pwm_strand_scorer.sv]
// ----------------------------------------------------------------------------
// motif_pwm_strand_scorer
// Position weight matrix scan of a DNA base stream, both strands.
// ----------------------------------------------------------------------------
// Input channel (in_push / in_full): opcode 0 loads one weight into row
// in_motif_position, column in_base; opcode 1 shifts in_base into the window.
// in_first_of_sequence with opcode 1 restarts the window count and base index.
// Once MOTIF_LEN bases of a sequence are held, each base produces one
// transaction on the result channel (out_empty / out_pop): forward and
// reverse-complement means (Q4.11, truncated toward zero) and window start.
// The front end takes one transaction per cycle while its job queue
// (QUEUE_DEPTH entries) has room. The back end retires a load as it pops
// it from the queue and a score job through a serial walk over the weight
// table's two read ports, then the sign, reciprocal-multiply divide and
// output stages. With the back end idle, a result follows its accepted
// transaction through that walk and those stages; jobs queued ahead of it
// add their own time.
// Reset clears the window, counters, queue and output; the weight table is
// not cleared and must be loaded first. A stalled receiver holds the result
// register; the back end then waits, the queue fills and in_full rises.
// ----------------------------------------------------------------------------
`default_nettype none

module motif_pwm_strand_scorer
  import mpss_pkg::*;
#(
  parameter int MOTIF_LEN   = MPSS_MOTIF_LEN,
  parameter int WEIGHT_BITS = MPSS_WEIGHT_BITS
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_push,
  output      logic                             in_full,
  input  wire logic                             in_opcode,
  input  wire logic                             in_first_of_sequence,
  input  wire logic [1:0]                       in_base,
  input  wire logic [3:0]                       in_motif_position,
  input  wire logic signed [FIELD_WEIGHT_W-1:0] in_weight,
  output      logic                             out_empty,
  input  wire logic                             out_pop,
  output      logic signed [15:0]               out_forward_mean,
  output      logic signed [15:0]               out_revcomp_mean,
  output      logic [31:0]                      out_window_start
);

  localparam int JOB_W = job_bits(MOTIF_LEN, WEIGHT_BITS);

  logic             f_push, q_full, q_empty, q_pop;
  logic [JOB_W-1:0] f_wdata, q_rdata;

  mpss_front #(
    .MOTIF_LEN   (MOTIF_LEN),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_front (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_push              (in_push),
    .in_full              (in_full),
    .in_opcode            (in_opcode),
    .in_first_of_sequence (in_first_of_sequence),
    .in_base              (in_base),
    .in_motif_position    (in_motif_position),
    .in_weight            (in_weight),
    .q_push               (f_push),
    .q_wdata              (f_wdata),
    .q_full               (q_full)
  );

  mpss_queue #(
    .WIDTH (JOB_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_push  (f_push),
    .q_wdata (f_wdata),
    .q_full  (q_full),
    .q_pop   (q_pop),
    .q_rdata (q_rdata),
    .q_empty (q_empty)
  );

  mpss_back #(
    .MOTIF_LEN   (MOTIF_LEN),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_empty          (q_empty),
    .q_rdata          (q_rdata),
    .q_pop            (q_pop),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_forward_mean (out_forward_mean),
    .out_revcomp_mean (out_revcomp_mean),
    .out_window_start (out_window_start)
  );

endmodule

`default_nettype wire

[test/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Testbench for motif_pwm_strand_scorer. The weight table is filled first, then
// a short directed table and a long random stream of loads and bases are
// pushed. An in-bench scoring model predicts every window result, unless the
// directed table gives it, and the expected values are compared field by field
// with the result channel. Sender idling and receiver stalling vary by phase.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top
  import mpss_pkg::*;
();

  localparam int MLEN       = MPSS_MOTIF_LEN;
  localparam int NCELL      = MLEN * 4;
  localparam int ITEMS      = 1950;
  localparam int PHASE_N    = 4;
  localparam int TAIL       = 60;
  localparam int IDLE_LIMIT = 2000;
  localparam int DIR_N      = 22;

  typedef struct packed {
    logic        op;
    logic        first;
    logic [1:0]  base;
    logic [3:0]  row;
    logic [15:0] wt;
  } txn_t;

  typedef struct packed {
    logic [15:0] fwd;
    logic [15:0] rev;
    logic [31:0] ws;
  } score_t;

  typedef struct packed {
    logic        op;
    logic        first;
    logic [1:0]  base;
    logic [3:0]  row;
    logic [15:0] wt;
    logic        typed;
    logic [15:0] fwd;
    logic [15:0] rev;
    logic [31:0] ws;
  } dir_row_t;

  dir_row_t dir_rows [DIR_N] = '{
    '{OP_SCORE, 1'b1, 2'd0, 4'd0,  16'h0000, 1'b0, 16'h0000, 16'h0000, 32'd0},
    '{OP_SCORE, 1'b0, 2'd1, 4'd0,  16'h0000, 1'b0, 16'h0000, 16'h0000, 32'd0},
    '{OP_SCORE, 1'b0, 2'd2, 4'd0,  16'h0000, 1'b0, 16'h0000, 16'h0000, 32'd0},
    '{OP_SCORE, 1'b0, 2'd3, 4'd0,  16'h0000, 1'b0, 16'h0000, 16'h0000, 32'd0},
    '{OP_SCORE, 1'b0, 2'd3, 4'd0,  16'h0000, 1'b0, 16'h0000, 16'h0000, 32'd0},
    '{OP_SCORE, 1'b0, 2'd2, 4'd0,  16'h0000, 1'b0, 16'h0000, 16'h0000, 32'd0},
    '{OP_SCORE, 1'b0, 2'd1, 4'd0,  16'h0000, 1'b0, 16'h0000, 16'h0000, 32'd0},
    '{OP_SCORE, 1'b0, 2'd0, 4'd0,  16'h0000, 1'b0, 16'h0000, 16'h0000, 32'd0},
    '{OP_SCORE, 1'b0, 2'd2, 4'd0,  16'h0000, 1'b0, 16'h0000, 16'h0000, 32'd0},
    '{OP_SCORE, 1'b0, 2'd1, 4'd0,  16'h0000, 1'b1, 16'h8000, 16'h8000, 32'd0},
    '{OP_LOAD,  1'b0, 2'd0, 4'd10, 16'h0000, 1'b0, 16'h0000, 16'h0000, 32'd0},
    '{OP_LOAD,  1'b1, 2'd3, 4'd15, 16'h7FFF, 1'b0, 16'h0000, 16'h0000, 32'd0},
    '{OP_SCORE, 1'b0, 2'd3, 4'd0,  16'h0000, 1'b1, 16'h8000, 16'h8000, 32'd1},
    '{OP_LOAD,  1'b0, 2'd0, 4'd0,  16'h7FFF, 1'b0, 16'h0000, 16'h0000, 32'd0},
    '{OP_LOAD,  1'b0, 2'd1, 4'd0,  16'h7FFF, 1'b0, 16'h0000, 16'h0000, 32'd0},
    '{OP_LOAD,  1'b0, 2'd2, 4'd0,  16'h7FFF, 1'b0, 16'h0000, 16'h0000, 32'd0},
    '{OP_LOAD,  1'b0, 2'd3, 4'd0,  16'h7FFF, 1'b0, 16'h0000, 16'h0000, 32'd0},
    '{OP_SCORE, 1'b0, 2'd0, 4'd0,  16'h0000, 1'b0, 16'h0000, 16'h0000, 32'd0},
    '{OP_LOAD,  1'b0, 2'd3, 4'd9,  16'hFFFF, 1'b0, 16'h0000, 16'h0000, 32'd0},
    '{OP_LOAD,  1'b0, 2'd0, 4'd9,  16'h0001, 1'b0, 16'h0000, 16'h0000, 32'd0},
    '{OP_SCORE, 1'b1, 2'd2, 4'd0,  16'h0000, 1'b0, 16'h0000, 16'h0000, 32'd0},
    '{OP_SCORE, 1'b0, 2'd1, 4'd0,  16'h0000, 1'b0, 16'h0000, 16'h0000, 32'd0}
  };

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_push = 1'b0;
  logic                      in_full;
  logic                      in_opcode = 1'b0;
  logic                      in_first_of_sequence = 1'b0;
  logic [1:0]                in_base = 2'd0;
  logic [3:0]                in_motif_position = 4'd0;
  logic signed [15:0]        in_weight = 16'sd0;
  logic                      out_empty;
  logic                      out_pop = 1'b0;
  logic signed [15:0]        out_forward_mean;
  logic signed [15:0]        out_revcomp_mean;
  logic [31:0]               out_window_start;

  logic signed [15:0] pwm_weights [NCELL];
  logic [1:0]         base_cells [MLEN];
  int unsigned        bases_held;
  logic [31:0]        seq_index;

  score_t expected_scores [$];
  score_t want;
  int     fails = 0;
  int     send_idle = 0;
  int     recv_stall = 0;
  int     quiet_cycles = 0;

  motif_pwm_strand_scorer uut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_push              (in_push),
    .in_full              (in_full),
    .in_opcode            (in_opcode),
    .in_first_of_sequence (in_first_of_sequence),
    .in_base              (in_base),
    .in_motif_position    (in_motif_position),
    .in_weight            (in_weight),
    .out_empty            (out_empty),
    .out_pop              (out_pop),
    .out_forward_mean     (out_forward_mean),
    .out_revcomp_mean     (out_revcomp_mean),
    .out_window_start     (out_window_start)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic pwm_predict(input txn_t t, output bit got, output score_t s);
    longint fsum;
    longint rsum;
    longint q;
    int     idx;
    got  = 1'b0;
    s    = '0;
    fsum = 0;
    rsum = 0;
    if (t.op == OP_LOAD) begin
      if (t.row < MLEN) begin
        idx = t.row * 4 + t.base;
        pwm_weights[idx] = t.wt;
      end
    end else begin
      if (t.first) begin
        bases_held = 0;
        seq_index  = '0;
      end
      for (int i = 0; i < MLEN - 1; i++) base_cells[i] = base_cells[i + 1];
      base_cells[MLEN - 1] = t.base;
      seq_index = seq_index + 32'd1;
      if (bases_held < MLEN) bases_held++;
      if (bases_held == MLEN) begin
        for (int i = 0; i < MLEN; i++) begin
          fsum += pwm_weights[i * 4 + base_cells[i]];
          rsum += pwm_weights[(MLEN - 1 - i) * 4 + COMPLEMENT[base_cells[i]]];
        end
        q = fsum / MLEN;
        s.fwd = q[15:0];
        q = rsum / MLEN;
        s.rev = q[15:0];
        s.ws  = seq_index - 32'(MLEN);
        got   = 1'b1;
      end
    end
  endtask

  task automatic push_item(input txn_t t, input bit typed, input score_t typed_score);
    bit     got;
    score_t s;
    while ($urandom_range(99) < send_idle) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push              <= 1'b1;
    in_opcode            <= t.op;
    in_first_of_sequence <= t.first;
    in_base              <= t.base;
    in_motif_position    <= t.row;
    in_weight            <= t.wt;
    @(posedge clk);
    while (in_full) @(posedge clk);
    pwm_predict(t, got, s);
    if (got) expected_scores.push_back(typed ? typed_score : s);
  endtask

  task automatic drain_results();
    in_push <= 1'b0;
    do @(posedge clk); while (expected_scores.size() != 0);
  endtask

  function automatic txn_t random_txn();
    txn_t t;
    int   roll;
    t.first = 1'($urandom_range(1));
    t.base  = 2'($urandom_range(3));
    t.row   = 4'($urandom_range(15));
    t.wt    = 16'($urandom);
    roll    = $urandom_range(99);
    if (roll < 15) begin
      t.op = OP_LOAD;
      if ($urandom_range(9) != 0) t.row = 4'($urandom_range(MLEN - 1));
      case ($urandom_range(9))
        0:       t.wt = 16'h8000;
        1:       t.wt = 16'h7FFF;
        2:       t.wt = 16'h0000;
        default: t.wt = 16'($urandom);
      endcase
    end else begin
      t.op    = OP_SCORE;
      t.first = ($urandom_range(59) == 0);
    end
    return t;
  endfunction

  always @(posedge clk) begin
    if (out_pop && !out_empty) begin
      if (expected_scores.size() == 0) begin
        $error("unexpected result: forward_mean %0d revcomp_mean %0d window_start %0d",
               out_forward_mean, out_revcomp_mean, out_window_start);
        fails++;
      end else begin
        want = expected_scores.pop_front();
        if (out_forward_mean !== want.fwd) begin
          $error("forward_mean: expected %0d, got %0d", $signed(want.fwd), out_forward_mean);
          fails++;
        end
        if (out_revcomp_mean !== want.rev) begin
          $error("revcomp_mean: expected %0d, got %0d", $signed(want.rev), out_revcomp_mean);
          fails++;
        end
        if (out_window_start !== want.ws) begin
          $error("window_start: expected %0d, got %0d", want.ws, out_window_start);
          fails++;
        end
      end
    end
    out_pop <= ($urandom_range(99) >= recv_stall);
  end

  always @(posedge clk) begin
    if ((in_push && !in_full) || (out_pop && !out_empty)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  initial begin
    txn_t   t;
    int     n;
    for (int i = 0; i < MLEN; i++) base_cells[i] = 2'd0;
    bases_held = 0;
    seq_index  = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    send_idle  = 12;
    recv_stall = 12;
    for (int r = 0; r < MLEN; r++) begin
      for (int c = 0; c < 4; c++) begin
        t = '{OP_LOAD, 1'b0, 2'(c), 4'(r), 16'h8000};
        push_item(t, 1'b0, '0);
      end
    end
    foreach (dir_rows[i]) begin
      t = '{dir_rows[i].op, dir_rows[i].first, dir_rows[i].base,
            dir_rows[i].row, dir_rows[i].wt};
      push_item(t, dir_rows[i].typed,
                '{dir_rows[i].fwd, dir_rows[i].rev, dir_rows[i].ws});
    end
    drain_results();

    for (int ph = 0; ph < PHASE_N; ph++) begin
      case (ph)
        0:       begin send_idle = 0;  recv_stall = 0;  end
        1:       begin send_idle = 69; recv_stall = 0;  end
        2:       begin send_idle = 0;  recv_stall = 69; end
        default: begin send_idle = 12; recv_stall = 12; end
      endcase
      n = 0;
      while (n < ITEMS / PHASE_N) begin
        t = random_txn();
        push_item(t, 1'b0, '0);
        if (!(t.op == OP_LOAD && t.row >= MLEN)) n++;
      end
      drain_results();
    end

    repeat (TAIL) @(posedge clk);
    if (fails == 0) $display("tb_top OK");
    else $display("tb_top NOT OK");
    $finish;
  end

endmodule

[motif_pwm_strand_scorer.f]
rtl/mpss_pkg.sv
rtl/mpss_queue.sv
rtl/mpss_front.sv
rtl/mpss_back.sv
rtl/motif_pwm_strand_scorer.sv
test/tb_top.sv
